// File: rtl/core/rrof_pkg.sv
`default_nettype none

package rrof_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    // wide enough for the largest grid and one step past a 256-wide row
    localparam int COORD_W = 13;
    localparam int CFG_W = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 9'd256;

    localparam logic [1:0] MASK_VAL_OUT = 2'd0;
    localparam logic [2:0] FULL_NEIGHBOURS = 3'd4;

    typedef enum logic [1:0] {
        OP_WRITE_MASK = 2'd0,
        OP_MARK       = 2'd1,
        OP_QUERY      = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_EAST  = 2'd0,
        DIR_WEST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_NORTH = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_QUERY = 3'd2,
        ST_DRAIN = 3'd3,
        ST_DONE  = 3'd4
    } state_t;

    typedef struct packed {
        op_t        opcode;
        logic [7:0] col;
        logic [7:0] row;
        logic [1:0] mask_value;
    } in_req_t;

    typedef struct packed {
        logic       is_edge;
        logic [2:0] neighbor_count;
        logic       touches_masked_out;
    } out_res_t;

    typedef struct packed {
        logic       mask_we;
        logic [1:0] mask_wdata;
        logic       occ_we;
        logic       occ_wdata;
    } store_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/rrof_nbr_unit.sv
`default_nettype none

module rrof_nbr_unit #(
    parameter int MAX_COLS = rrof_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = rrof_pkg::DEF_MAX_ROWS
) (
    input  wire logic [7:0]                   col,
    input  wire logic [7:0]                   row,
    input  wire rrof_pkg::dir_t               dir,
    input  wire logic                         centre,
    input  wire logic [rrof_pkg::COORD_W-1:0] eff_w,
    input  wire logic [rrof_pkg::COORD_W-1:0] eff_h,
    output logic                              valid,
    output logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0] addr
);
    import rrof_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] nc;
    logic [COORD_W-1:0] nr;
    logic               under;

    assign c = {{(COORD_W-8){1'b0}}, col};
    assign r = {{(COORD_W-8){1'b0}}, row};

    always_comb
    begin
        nc = c;
        nr = r;
        under = 1'b0;
        if (!centre)
        begin
            case (dir)
                DIR_EAST:
                begin
                    nc = c + COORD_W'(1);
                end
                DIR_WEST:
                begin
                    nc = c - COORD_W'(1);
                    under = (col == 8'd0);
                end
                DIR_SOUTH:
                begin
                    nr = r + COORD_W'(1);
                end
                DIR_NORTH:
                begin
                    nr = r - COORD_W'(1);
                    under = (row == 8'd0);
                end
                default:
                begin
                    under = 1'b1;
                end
            endcase
        end
    end

    assign valid = !under && (nc < eff_w) && (nr < eff_h);
    assign addr = {nr[RW-1:0], nc[CW-1:0]};

endmodule

`default_nettype wire

// File: rtl/core/rrof_store.sv
`default_nettype none

module rrof_store #(
    parameter int MAX_COLS = rrof_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = rrof_pkg::DEF_MAX_ROWS
) (
    input  wire logic                        clk,
    input  wire rrof_pkg::store_ctrl_t       ctrl,
    input  wire logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0] addr,
    output logic [1:0]                       mask_rd,
    output logic                             occ_rd
);
    import rrof_pkg::*;

    localparam int AW = $clog2(MAX_COLS) + $clog2(MAX_ROWS);
    localparam int DEPTH = 1 << AW;

    logic [1:0] mask_mem [DEPTH];
    logic       occ_mem [DEPTH];

    // one port per store: write and registered read at the same address
    always_ff @(posedge clk)
    begin
        if (ctrl.mask_we)
        begin
            mask_mem[addr] <= ctrl.mask_wdata;
        end
        mask_rd <= mask_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.occ_we)
        begin
            occ_mem[addr] <= ctrl.occ_wdata;
        end
        occ_rd <= occ_mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/raster_region_open_edge_flagger.sv
// a query reads the four neighbours in the query state, then goes through drain and done
// before its result shows; the input stalls meanwhile, as the reads share the single store
// ports and the shared neighbour address unit; a write or mark is taken every cycle while idle
// a clear holds the input stalled while it sweeps 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells
// reset: rst_n asynchronous, then the same clearing sweep of the occupancy store runs
// grid size registers reset to 256; the mask store is not initialised
`default_nettype none

module raster_region_open_edge_flagger #(
    parameter int MAX_COLS = rrof_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = rrof_pkg::DEF_MAX_ROWS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rrof_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rrof_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire rrof_pkg::in_req_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output rrof_pkg::out_res_t                  out_data
);
    import rrof_pkg::*;

    localparam int AW = $clog2(MAX_COLS) + $clog2(MAX_ROWS);

    state_t             state_reg, state_next;
    dir_t               dir_reg, dir_next;
    logic [7:0]         col_reg, col_next;
    logic [7:0]         row_reg, row_next;
    logic               on_grid_reg, on_grid_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [2:0]         count_reg, count_next;
    logic               touches_reg, touches_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;
    out_res_t           out_data_reg, out_data_next;
    logic [CFG_W-1:0]   grid_width_reg, grid_height_reg;

    logic [COORD_W-1:0] eff_w;
    logic [COORD_W-1:0] eff_h;
    logic [7:0]         unit_col;
    logic [7:0]         unit_row;
    logic               unit_centre;
    logic               unit_valid;
    logic [AW-1:0]      unit_addr;
    logic [AW-1:0]      store_addr;
    store_ctrl_t        store_ctrl;
    logic [1:0]         mask_rd;
    logic               occ_rd;
    logic               accept;
    logic [1:0]         dir_inc;

    assign eff_w = ({{(COORD_W-CFG_W){1'b0}}, grid_width_reg} > COORD_W'(MAX_COLS))
                   ? COORD_W'(MAX_COLS) : {{(COORD_W-CFG_W){1'b0}}, grid_width_reg};
    assign eff_h = ({{(COORD_W-CFG_W){1'b0}}, grid_height_reg} > COORD_W'(MAX_ROWS))
                   ? COORD_W'(MAX_ROWS) : {{(COORD_W-CFG_W){1'b0}}, grid_height_reg};

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    // the addressed cell while idle, its neighbours while querying
    assign unit_centre = (state_reg == ST_IDLE);
    assign unit_col = unit_centre ? in_data.col : col_reg;
    assign unit_row = unit_centre ? in_data.row : row_reg;

    rrof_nbr_unit #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_nbr (
        .col    (unit_col),
        .row    (unit_row),
        .dir    (dir_reg),
        .centre (unit_centre),
        .eff_w  (eff_w),
        .eff_h  (eff_h),
        .valid  (unit_valid),
        .addr   (unit_addr)
    );

    assign store_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : unit_addr;

    always_comb
    begin
        store_ctrl.mask_we = accept && (in_data.opcode == OP_WRITE_MASK) && unit_valid;
        store_ctrl.mask_wdata = in_data.mask_value;
        store_ctrl.occ_we = (state_reg == ST_CLEAR)
                            || (accept && (in_data.opcode == OP_MARK) && unit_valid);
        store_ctrl.occ_wdata = (state_reg != ST_CLEAR);
    end

    rrof_store #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_store (
        .clk     (clk),
        .ctrl    (store_ctrl),
        .addr    (store_addr),
        .mask_rd (mask_rd),
        .occ_rd  (occ_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        dir_next = dir_reg;
        col_next = col_reg;
        row_next = row_reg;
        on_grid_next = on_grid_reg;
        rd_pend_next = 1'b0;
        rd_valid_next = 1'b0;
        count_next = count_reg;
        touches_next = touches_reg;
        clr_cnt_next = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        dir_inc = dir_reg + 2'd1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // fold in the neighbour read issued last cycle
        if (rd_pend_reg && rd_valid_reg)
        begin
            count_next = count_reg + {2'b00, occ_rd};
            touches_next = touches_reg || (mask_rd == MASK_VAL_OUT);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.opcode)
                        OP_QUERY:
                        begin
                            state_next = ST_QUERY;
                            dir_next = DIR_EAST;
                            col_next = in_data.col;
                            row_next = in_data.row;
                            on_grid_next = unit_valid;
                            count_next = 3'd0;
                            touches_next = 1'b0;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                            clr_cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_QUERY:
            begin
                rd_pend_next = 1'b1;
                rd_valid_next = on_grid_reg && unit_valid;
                dir_next = dir_t'(dir_inc);
                if (dir_reg == DIR_NORTH)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.is_edge = on_grid_reg && (count_reg < FULL_NEIGHBOURS)
                                            && !touches_reg;
                    out_data_next.neighbor_count = count_reg;
                    out_data_next.touches_masked_out = touches_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            dir_reg <= DIR_EAST;
            on_grid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            count_reg <= 3'd0;
            touches_reg <= 1'b0;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg <= dir_next;
            on_grid_reg <= on_grid_next;
            rd_pend_reg <= rd_pend_next;
            rd_valid_reg <= rd_valid_next;
            count_reg <= count_next;
            touches_reg <= touches_next;
            clr_cnt_reg <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        row_reg <= row_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_SIZE_RESET;
            grid_height_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:
                begin
                    grid_width_reg <= cfg_data;
                end
                CFG_GRID_HEIGHT:
                begin
                    grid_height_reg <= cfg_data;
                end
                default:
                begin
                    grid_width_reg <= grid_width_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rrof_checker.sv
`default_nettype none

module rrof_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire rrof_pkg::in_req_t              in_data,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire rrof_pkg::out_res_t             out_data
);
    import rrof_pkg::*;

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.neighbor_count <= FULL_NEIGHBOURS)
        else $error("neighbour count above four");

    a_edge_rule: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_edge |->
            out_data.neighbor_count < FULL_NEIGHBOURS && !out_data.touches_masked_out)
        else $error("edge flagged against the rule");

    // a query keeps the block busy while the neighbours are read
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode == OP_QUERY |=> in_stall)
        else $error("request taken during a query");

    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.opcode == OP_WRITE_MASK
            || in_data.opcode == OP_MARK) |=> !in_stall)
        else $error("mask write or mark did not finish in one cycle");

endmodule

bind raster_region_open_edge_flagger rrof_checker u_rrof_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
